// File: design/best_fit_allocator_coalescing_unit_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef BEST_FIT_ALLOCATOR_COALESCING_UNIT_ASSERT_SVH
`define BEST_FIT_ALLOCATOR_COALESCING_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BFA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BFA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BFA_ASSERT(label, clk, rst_n, prop, msg)
`define BFA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: design/bfa_pkg.sv
package bfa_pkg;
  localparam int unsigned MaxBlocks   = 2048;
  localparam int unsigned MaxRequests = 1024;
  localparam int unsigned AddrBits    = 31;
  localparam int unsigned BlkIdxW     = $clog2(MaxBlocks);
  localparam int unsigned ReqIdxW     = $clog2(MaxRequests);
  localparam int unsigned ReqCntW     = $clog2(MaxRequests + 1);
  localparam int unsigned TargetW     = 10;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [BlkIdxW-1:0]  blk_idx_t;

  typedef struct packed {
    logic  valid;
    logic  used;
    addr_t begin_a;
    addr_t finish_a;
  } blk_t;

  typedef struct packed {
    logic  live;
    addr_t begin_a;
  } req_ent_t;

  typedef struct packed {
    logic  cmd;
    addr_t alloc_size;
    logic [TargetW-1:0] target_request;
  } req_t;

  typedef struct packed {
    logic  failed;
    addr_t address;
  } rsp_t;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StReqRead,
    StFindUsed,
    StScanFit,
    StSplitRead,
    StSplitWrite,
    StScanPrev,
    StScanNext,
    StMerge,
    StRespond
  } state_e;
endpackage

// File: design/bfa_stream_if.sv
interface bfa_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/bfa_block_ram.sv
module bfa_block_ram (
  input  logic              clk_i,
  input  logic              we_i,
  input  bfa_pkg::blk_idx_t waddr_i,
  input  bfa_pkg::blk_t     wdata_i,
  input  bfa_pkg::blk_idx_t raddr_i,
  output bfa_pkg::blk_t     rdata_o
);
  bfa_pkg::blk_t mem_q [bfa_pkg::MaxBlocks];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: design/best_fit_allocator_coalescing_unit.sv
// Channel   Dir  Payload
// req       in   cmd, alloc_size, target_request
// rsp       out  failed, address (allocate beats only)
// cfg       in   heap_size write, to be made only while idle (the block does not enforce it)
// After reset a clearing pass marks every block and request entry invalid; the
// request channel is held off until it ends.
// An allocate makes one pass over the block memory to find the best fit and the
// first free slot, then does the split writes. A free makes a pass to find the
// used block plus up to two passes for the free neighbors. The single read port
// of the block memory is why each search is a pass. One request is in work at a
// time, and a pending response holds off the next input beat until it is taken.
`include "best_fit_allocator_coalescing_unit_assert.svh"
module best_fit_allocator_coalescing_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  bfa_pkg::addr_t       cfg_wdata_i,
  bfa_stream_if.sink           req,
  bfa_stream_if.source         rsp
);
  localparam int unsigned BW = bfa_pkg::BlkIdxW;

  bfa_pkg::state_e state_q, state_d;
  bfa_pkg::addr_t  heap_size_q;
  logic            seeded_q;
  bfa_pkg::req_ent_t req_mem [bfa_pkg::MaxRequests];
  bfa_pkg::req_ent_t req_rd_q;
  logic [bfa_pkg::ReqCntW-1:0] count_q;

  bfa_pkg::req_t   cur_q;
  logic            have_num_q;
  logic [bfa_pkg::ReqIdxW-1:0] num_q;

  // Scan state: address issued, and the data pointer matching the registered read data.
  logic [BW:0]     scan_q;
  logic            rd_pend_q;
  bfa_pkg::blk_idx_t rd_idx_q;

  logic            found_q, slot_ok_q;
  bfa_pkg::blk_idx_t best_q, slot_q;
  bfa_pkg::addr_t  best_sz_q, best_begin_q;
  bfa_pkg::blk_t   work_q;   // block being freed / split

  logic            rsp_valid_q;
  bfa_pkg::rsp_t   rsp_q;

  // The shortened used block of a split is written in the cycle after the new piece.
  logic            fix_we_q;

  // Block memory port.
  logic              ram_we;
  bfa_pkg::blk_idx_t ram_waddr, ram_raddr;
  bfa_pkg::blk_t     ram_wdata, ram_rdata;

  // Request memory write port.
  logic                        req_we;
  logic [bfa_pkg::ReqIdxW-1:0] req_waddr;
  bfa_pkg::req_ent_t           req_wdata;

  bfa_block_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic accept, scan_done, rd_vld, hit_used, hit_prev, hit_next, fit_better;
  logic do_split, grant;
  bfa_pkg::addr_t rd_sz;

  assign req.ready = (state_q == bfa_pkg::StIdle) && !rsp_valid_q;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_q;
  assign ram_raddr = scan_q[BW-1:0];
  assign scan_done = scan_q[BW] && !rd_pend_q;
  assign rd_vld    = rd_pend_q && ram_rdata.valid;
  assign rd_sz     = ram_rdata.finish_a - ram_rdata.begin_a;

  assign hit_used  = rd_vld && ram_rdata.used && (ram_rdata.begin_a == req_rd_q.begin_a);
  assign hit_prev  = rd_vld && !ram_rdata.used && (rd_idx_q != best_q) &&
                     (ram_rdata.finish_a == work_q.begin_a);
  assign hit_next  = rd_vld && !ram_rdata.used && (rd_idx_q != best_q) &&
                     (ram_rdata.begin_a == work_q.finish_a);
  assign fit_better = rd_vld && !ram_rdata.used && (rd_sz >= cur_q.alloc_size) &&
                      (!found_q || rd_sz < best_sz_q ||
                       (rd_sz == best_sz_q && ram_rdata.begin_a < best_begin_q));

  // A split without a free slot fails like a miss.
  assign do_split = best_sz_q > cur_q.alloc_size;
  assign grant    = found_q && !(do_split && !slot_ok_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bfa_pkg::StClear:     if (scan_q[BW-1:0] == '1) state_d = bfa_pkg::StIdle;
      bfa_pkg::StIdle:      if (accept) state_d = bfa_pkg::StReqRead;
      bfa_pkg::StReqRead: begin
        if (cur_q.cmd == bfa_pkg::CmdFree) begin
          state_d = req_rd_q.live ? bfa_pkg::StFindUsed : bfa_pkg::StIdle;
        end else if (!have_num_q || cur_q.alloc_size == '0) begin
          state_d = bfa_pkg::StRespond;
        end else begin
          state_d = bfa_pkg::StScanFit;
        end
      end
      bfa_pkg::StFindUsed: begin
        if (hit_used) state_d = bfa_pkg::StScanPrev;
        else if (scan_done) state_d = bfa_pkg::StIdle;
      end
      bfa_pkg::StScanFit:   if (scan_done) state_d = bfa_pkg::StSplitRead;
      bfa_pkg::StSplitRead: state_d = bfa_pkg::StSplitWrite;
      bfa_pkg::StSplitWrite: state_d = bfa_pkg::StRespond;
      bfa_pkg::StScanPrev:  if (hit_prev || scan_done) state_d = bfa_pkg::StScanNext;
      bfa_pkg::StScanNext:  if (hit_next || scan_done) state_d = bfa_pkg::StMerge;
      bfa_pkg::StMerge:     state_d = bfa_pkg::StIdle;
      bfa_pkg::StRespond:   state_d = bfa_pkg::StIdle;
      default:              state_d = bfa_pkg::StIdle;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_q;
    ram_wdata = work_q;
    case (state_q)
      bfa_pkg::StClear: begin
        ram_we    = 1'b1;
        ram_waddr = scan_q[BW-1:0];
        ram_wdata = '0;
      end
      bfa_pkg::StIdle: begin
        if (accept && !seeded_q) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = '{valid: 1'b1, used: 1'b0, begin_a: '0, finish_a: heap_size_q};
        end
      end
      bfa_pkg::StSplitWrite: begin
        if (grant) begin
          ram_we = 1'b1;
          if (do_split) begin
            ram_waddr = slot_q;
            ram_wdata = '{valid: 1'b1, used: 1'b0,
                          begin_a: work_q.begin_a + cur_q.alloc_size,
                          finish_a: work_q.finish_a};
          end
        end
      end
      bfa_pkg::StScanPrev: begin
        if (hit_prev) begin
          ram_we          = 1'b1;
          ram_waddr       = rd_idx_q;
          ram_wdata       = ram_rdata;
          ram_wdata.valid = 1'b0;
        end
      end
      bfa_pkg::StScanNext: begin
        if (hit_next) begin
          ram_we          = 1'b1;
          ram_waddr       = rd_idx_q;
          ram_wdata       = ram_rdata;
          ram_wdata.valid = 1'b0;
        end
      end
      bfa_pkg::StMerge: begin
        ram_we = 1'b1;
      end
      bfa_pkg::StRespond: begin
        // The Respond cycle carries no other write, so the used half of a
        // split goes back here.
        if (fix_we_q) ram_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    req_we    = 1'b0;
    req_waddr = num_q;
    req_wdata = '{live: 1'b1, begin_a: work_q.begin_a};
    case (state_q)
      bfa_pkg::StClear: begin
        req_we    = 1'b1;
        req_waddr = scan_q[bfa_pkg::ReqIdxW-1:0];
        req_wdata = '0;
      end
      bfa_pkg::StReqRead: begin
        if (cur_q.cmd == bfa_pkg::CmdFree && req_rd_q.live) begin
          req_we    = 1'b1;
          req_waddr = cur_q.target_request[bfa_pkg::ReqIdxW-1:0];
          req_wdata = '{live: 1'b0, begin_a: req_rd_q.begin_a};
        end
      end
      bfa_pkg::StSplitWrite: begin
        if (grant && have_num_q) req_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q    <= req.data;
      req_rd_q <= req_mem[req.data.target_request[bfa_pkg::ReqIdxW-1:0]];
    end
    if (req_we) begin
      req_mem[req_waddr] <= req_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfa_pkg::StClear;
      heap_size_q <= bfa_pkg::addr_t'(65536);
      seeded_q    <= 1'b0;
      count_q     <= '0;
      have_num_q  <= 1'b0;
      num_q       <= '0;
      scan_q      <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      found_q     <= 1'b0;
      slot_ok_q   <= 1'b0;
      best_q      <= '0;
      slot_q      <= '0;
      best_sz_q   <= '0;
      best_begin_q <= '0;
      work_q      <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) heap_size_q <= cfg_wdata_i;
      if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;

      // Scan address walk; restarts whenever a scan state is entered.
      if (state_d != state_q) begin
        scan_q    <= '0;
        rd_pend_q <= 1'b0;
      end else if (!scan_q[BW]) begin
        rd_idx_q  <= scan_q[BW-1:0];
        rd_pend_q <= 1'b1;
        scan_q    <= scan_q + 1'b1;
      end else begin
        rd_pend_q <= 1'b0;
      end

      case (state_q)
        bfa_pkg::StIdle: begin
          if (accept) begin
            if (!seeded_q) seeded_q <= 1'b1;
            have_num_q <= count_q < bfa_pkg::ReqCntW'(bfa_pkg::MaxRequests);
            num_q      <= count_q[bfa_pkg::ReqIdxW-1:0];
            if (count_q < bfa_pkg::ReqCntW'(bfa_pkg::MaxRequests)) count_q <= count_q + 1'b1;
            found_q    <= 1'b0;
            slot_ok_q  <= 1'b0;
            rsp_q      <= '{failed: 1'b1, address: '0};
          end
        end
        bfa_pkg::StFindUsed: begin
          if (hit_used) begin
            best_q <= rd_idx_q;
            work_q <= '{valid: 1'b1, used: 1'b0, begin_a: ram_rdata.begin_a,
                        finish_a: ram_rdata.finish_a};
          end
        end
        bfa_pkg::StScanFit: begin
          if (fit_better) begin
            found_q      <= 1'b1;
            best_q       <= rd_idx_q;
            best_sz_q    <= rd_sz;
            best_begin_q <= ram_rdata.begin_a;
          end
          if (rd_pend_q && !ram_rdata.valid && !slot_ok_q) begin
            slot_ok_q <= 1'b1;
            slot_q    <= rd_idx_q;
          end
        end
        bfa_pkg::StSplitRead: begin
          work_q <= '{valid: 1'b1, used: 1'b1, begin_a: best_begin_q,
                      finish_a: best_begin_q + best_sz_q};
        end
        bfa_pkg::StSplitWrite: begin
          if (grant) begin
            work_q.finish_a <= best_begin_q + cur_q.alloc_size;
            rsp_q <= '{failed: 1'b0, address: best_begin_q + 1'b1};
          end
        end
        bfa_pkg::StScanPrev: begin
          if (hit_prev) work_q.begin_a <= ram_rdata.begin_a;
        end
        bfa_pkg::StScanNext: begin
          if (hit_next) work_q.finish_a <= ram_rdata.finish_a;
        end
        bfa_pkg::StRespond: begin
          rsp_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_we_q <= 1'b0;
    end else begin
      fix_we_q <= (state_q == bfa_pkg::StSplitWrite) && found_q && do_split && slot_ok_q;
    end
  end

  `BFA_ASSERT(a_rsp_hold, clk_i, rst_ni, !(rsp_valid_q && accept), "beat taken while response pending")
  `BFA_ASSERT_NEXT(a_rsp_only_alloc, clk_i, rst_ni, state_q == bfa_pkg::StRespond, rsp_valid_q, "respond lost")
  `BFA_ASSERT(a_count_sat, clk_i, rst_ni, count_q <= bfa_pkg::ReqCntW'(bfa_pkg::MaxRequests), "count overflow")
endmodule
